FILE: sv/ldfr_pkg.sv
// constants shared by the line deframer: byte codes, field widths, config reset
// no dependencies
package ldfr_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 16;
    localparam int CFG_W  = 7;

    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

    localparam logic [CFG_W-1:0] CFG_MAX_LEN_RESET = 7'd64;

    // tuser codes on the request side
    typedef enum logic {
        FUNC_DATA  = 1'b0,
        FUNC_FLUSH = 1'b1
    } t_func;

endpackage

FILE: sv/ldfr_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module ldfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/line_deframer_with_length_cap_core.sv
// line deframer top level: splits a byte stream at LF or flush, strips a trailing CR,
// drops blank and overlong lines; uses ldfr_pkg and ldfr_ram for the line buffer
// on LF or flush the first line byte passes the state, ram read and output registers,
// then one byte per cycle while the receiver is ready (single ram read port); throughput:
// one request per cycle while buffering; no request is taken until the last line byte
// is delivered; reset: sync active low, clears control state, cap 64, ram untouched
module line_deframer_with_length_cap_core #(
    parameter int LINE_MAX = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // config: max_line_length
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,

    // request side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] func

    // line output side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] line_byte, [23:8] overlong_count
    output logic        m_axis_tlast    // last_of_line
);

    localparam int LEN_W  = $clog2(LINE_MAX + 1);
    localparam int ADDR_W = $clog2(LINE_MAX);
    localparam int CFG_W  = ldfr_pkg::CFG_W;
    localparam int BYTE_W = ldfr_pkg::BYTE_W;
    localparam int CNT_W  = ldfr_pkg::CNT_W;

    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(LINE_MAX);
    localparam logic [CFG_W-1:0] CAP_LIMIT = CFG_W'(LINE_MAX);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // state
    t_state              r_state,      n_state;
    logic [CFG_W-1:0]    r_max_len;
    logic [LEN_W-1:0]    r_len,        n_len;
    logic                r_cr_held,    n_cr_held;
    logic                r_discard,    n_discard;
    logic [CNT_W-1:0]    r_dropped,    n_dropped;

    // emit sequencing
    logic [LEN_W-1:0]    r_line_n,     n_line_n;
    logic [LEN_W-1:0]    r_rd_idx,     n_rd_idx;
    logic                r_pend,       n_pend;
    logic                r_pend_last,  n_pend_last;
    logic                r_out_valid,  n_out_valid;
    logic [BYTE_W-1:0]   r_out_byte,   n_out_byte;
    logic                r_out_last,   n_out_last;
    logic                r_skid_valid, n_skid_valid;
    logic [BYTE_W-1:0]   r_skid_byte,  n_skid_byte;
    logic                r_skid_last,  n_skid_last;

    // ram controls
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [BYTE_W-1:0]   w_wdata;
    logic                w_re;
    logic [BYTE_W-1:0]   w_rdata;

    // request decode
    logic                w_req;
    logic                w_flush;
    logic                w_is_cr;
    logic [CFG_W-1:0]    w_cap;
    logic [CFG_W-1:0]    w_len_ext;
    logic [CFG_W-1:0]    w_len_a_ext;
    logic [LEN_W-1:0]    w_len_a;
    logic                w_ov_cr;
    logic                w_ov_byte;
    logic [CNT_W-1:0]    w_dropped_inc;

    // output side
    logic                w_take;
    logic                w_more;
    logic [1:0]          w_fill;

    ldfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_MAX)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_rd_idx[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_req         = s_axis_tvalid && s_axis_tready;
    assign w_flush       = (s_axis_tuser == ldfr_pkg::FUNC_FLUSH)
                           || (s_axis_tdata == ldfr_pkg::CHAR_LF);
    assign w_is_cr       = (s_axis_tdata == ldfr_pkg::CHAR_CR);

    // cap in force saturates at the buffer depth
    assign w_cap         = (r_max_len > CAP_LIMIT) ? CAP_LIMIT : r_max_len;
    assign w_len_ext     = CFG_W'(r_len);

    // a held CR goes in first; it is already in the ram at index r_len
    assign w_ov_cr       = r_cr_held && ((w_len_ext >= w_cap) || (r_len >= LEN_MAX));
    assign w_len_a       = r_cr_held ? (r_len + LEN_W'(1)) : r_len;
    assign w_len_a_ext   = CFG_W'(w_len_a);
    assign w_ov_byte     = (w_len_a_ext >= w_cap) || (w_len_a >= LEN_MAX);

    assign w_dropped_inc = (r_dropped != '1) ? (r_dropped + CNT_W'(1)) : r_dropped;

    // a new CR is written ahead at its would-be index, so a later placement
    // only bumps the length and each request makes at most one ram write
    assign w_waddr = w_len_a[ADDR_W-1:0];
    assign w_wdata = s_axis_tdata;

    assign w_take  = r_out_valid && m_axis_tready;
    assign w_more  = (r_rd_idx != r_line_n);
    // bytes held or arriving after this edge
    assign w_fill  = 2'(r_out_valid) + 2'(r_skid_valid) + 2'(r_pend) - 2'(w_take);
    assign w_re    = (r_state == ST_EMIT) && w_more && (w_fill <= 2'd1);

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_cr_held    = r_cr_held;
        n_discard    = r_discard;
        n_dropped    = r_dropped;
        n_line_n     = r_line_n;
        n_rd_idx     = r_rd_idx;
        w_we         = 1'b0;

        if (w_req) begin
            if (w_flush) begin
                n_len     = '0;
                n_cr_held = 1'b0;
                n_discard = 1'b0;
                if (!r_discard && (r_len != '0)) begin
                    if (w_len_ext > w_cap) begin
                        // cap lowered under a buffered line
                        n_dropped = w_dropped_inc;
                    end else begin
                        n_line_n = r_len;
                        n_rd_idx = '0;
                        n_state  = ST_EMIT;
                    end
                end
            end else if (!r_discard) begin
                if (w_ov_cr) begin
                    n_dropped = w_dropped_inc;
                    n_len     = '0;
                    n_cr_held = 1'b0;
                    n_discard = 1'b1;
                end else if (w_is_cr) begin
                    n_len     = w_len_a;
                    n_cr_held = 1'b1;
                    w_we      = (w_len_a < LEN_MAX);
                end else if (w_ov_byte) begin
                    n_dropped = w_dropped_inc;
                    n_len     = '0;
                    n_cr_held = 1'b0;
                    n_discard = 1'b1;
                end else begin
                    n_len     = w_len_a + LEN_W'(1);
                    n_cr_held = 1'b0;
                    w_we      = 1'b1;
                end
            end
        end

        if (w_re) begin
            n_rd_idx = r_rd_idx + LEN_W'(1);
        end

        if ((r_state == ST_EMIT) && !w_more && !r_pend && !r_skid_valid
            && (!r_out_valid || w_take)) begin
            n_state = ST_IDLE;
        end
    end

    // output register plus one skid entry behind the ram read
    always_comb begin
        n_pend       = w_re;
        n_pend_last  = (r_rd_idx + LEN_W'(1)) == r_line_n;
        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_skid_valid = r_skid_valid;
        n_skid_byte  = r_skid_byte;
        n_skid_last  = r_skid_last;

        if (w_take) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_byte   = r_skid_byte;
                n_out_last   = r_skid_last;
                n_skid_valid = r_pend;
                n_skid_byte  = w_rdata;
                n_skid_last  = r_pend_last;
            end else begin
                n_out_valid  = r_pend;
                n_out_byte   = w_rdata;
                n_out_last   = r_pend_last;
            end
        end else if (r_pend) begin
            if (!r_out_valid) begin
                n_out_valid = 1'b1;
                n_out_byte  = w_rdata;
                n_out_last  = r_pend_last;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_byte  = w_rdata;
                n_skid_last  = r_pend_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_max_len    <= ldfr_pkg::CFG_MAX_LEN_RESET;
            r_len        <= '0;
            r_cr_held    <= 1'b0;
            r_discard    <= 1'b0;
            r_dropped    <= '0;
            r_line_n     <= '0;
            r_rd_idx     <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
            r_len        <= n_len;
            r_cr_held    <= n_cr_held;
            r_discard    <= n_discard;
            r_dropped    <= n_dropped;
            r_line_n     <= n_line_n;
            r_rd_idx     <= n_rd_idx;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end

        // payload, no reset needed
        r_pend_last <= n_pend_last;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_skid_byte <= n_skid_byte;
        r_skid_last <= n_skid_last;
    end

    // drop count is frozen while a line drains, so it is shown straight from state
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_dropped, r_out_byte};
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: sim/tb_top.sv
// testbench for line_deframer_with_length_cap_core: drives random and directed byte
// streams and compares every emitted line byte against a built-in line predictor
// depends on ldfr_pkg and the core rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_MAX   = 64;
    localparam int STALL_MAX  = 5000;  // cycles without any handshake before giving up
    localparam int LONG_HOLD  = 300;   // receiver hold-off that fills the block up

    // one emitted line byte as seen on the output stream
    typedef struct packed {
        logic [7:0]  line_byte;
        logic        last;
        logic [15:0] dropped;
    } t_line_beat;

    // line predictor plus the queue of line bytes still owed by the block
    class t_line_scoreboard;
        logic [7:0]   line_mem [LINE_MAX];
        int unsigned  line_len;
        bit           cr_held;
        bit           discarding;
        logic [15:0]  drop_count;
        logic [6:0]   max_len;
        t_line_beat   owed_beats [$];
        int           errors;

        function new();
            line_len   = 0;
            cr_held    = 0;
            discarding = 0;
            drop_count = '0;
            max_len    = ldfr_pkg::CFG_MAX_LEN_RESET;
            errors     = 0;
        endfunction

        function int unsigned cap();
            return (max_len < LINE_MAX) ? max_len : LINE_MAX;
        endfunction

        function void count_drop();
            if (drop_count != 16'hFFFF) begin
                drop_count++;
            end
        endfunction

        // a byte that would push the line past the cap sends it into discard
        function void place(logic [7:0] d);
            if (line_len + 1 > cap() || line_len >= LINE_MAX) begin
                count_drop();
                line_len   = 0;
                cr_held    = 0;
                discarding = 1;
                return;
            end
            line_mem[line_len] = d;
            line_len++;
        endfunction

        // work out what one accepted request makes the block emit
        function void note_request(ldfr_pkg::t_func f, logic [7:0] d);
            int unsigned n;
            t_line_beat  beat;
            if (f == ldfr_pkg::FUNC_FLUSH || d == ldfr_pkg::CHAR_LF) begin
                n        = line_len;
                line_len = 0;
                cr_held  = 0;
                if (discarding) begin
                    // end of an overlong line: nothing out, nothing counted
                    discarding = 0;
                    return;
                end
                if (n == 0) begin
                    return;
                end
                // cap may have dropped while the line sat in the buffer
                if (n > cap()) begin
                    count_drop();
                    return;
                end
                for (int unsigned i = 0; i < n; i++) begin
                    beat.line_byte = line_mem[i];
                    beat.last      = (i + 1 == n);
                    beat.dropped   = drop_count;
                    owed_beats.push_back(beat);
                end
                return;
            end
            if (discarding) begin
                return;
            end
            // a held CR followed by a non-LF byte becomes a line byte
            if (cr_held) begin
                cr_held = 0;
                place(ldfr_pkg::CHAR_CR);
                if (discarding) begin
                    return;
                end
            end
            if (d == ldfr_pkg::CHAR_CR) begin
                cr_held = 1;
            end else begin
                place(d);
            end
        endfunction

        function void check_beat(logic [7:0] d, logic last, logic [15:0] dropped);
            t_line_beat want;
            if (owed_beats.size() == 0) begin
                $display("%0t: unexpected line byte, expected none actual %h last %b dropped %0d",
                         $time, d, last, dropped);
                errors++;
                return;
            end
            want = owed_beats.pop_front();
            if (want.line_byte !== d) begin
                $display("%0t: line_byte mismatch, expected %h actual %h",
                         $time, want.line_byte, d);
                errors++;
            end
            if (want.last !== last) begin
                $display("%0t: tlast mismatch, expected %b actual %b",
                         $time, want.last, last);
                errors++;
            end
            if (want.dropped !== dropped) begin
                $display("%0t: overlong_count mismatch, expected %0d actual %0d",
                         $time, want.dropped, dropped);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [7:0] line_byte, [23:8] overlong_count
    logic        m_axis_tlast;   // last_of_line

    t_line_scoreboard sb = new();

    bit  idle_on      = 1;   // random gaps on both sides
    bit  hold_request = 0;   // asks the receiver for one long hold-off
    int  requests_sent = 0;
    int  stall_cycles  = 0;

    line_deframer_with_length_cap_core #(
        .LINE_MAX (LINE_MAX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // handshake monitor: both sides sampled at the edge, before the block updates
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_beat(m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[23:8]);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_request(ldfr_pkg::t_func'(s_axis_tuser), s_axis_tdata);
            end
            // watchdog on cycles with no progress on either side
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles + 1 >= STALL_MAX) begin
                $display("line_deframer_with_length_cap_core test failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // receiver: random ready bursts, one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_request = 0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // offer one request and hold it until the block takes it
    task automatic send_request(ldfr_pkg::t_func f, logic [7:0] d);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(0, 255));
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic send_data(logic [7:0] d);
        send_request(ldfr_pkg::FUNC_DATA, d);
    endtask

    task automatic send_flush();
        // byte lane is don't-care on a flush, so put noise there
        send_request(ldfr_pkg::FUNC_FLUSH, 8'($urandom_range(0, 255)));
    endtask

    // stop offering and wait until every owed line byte has come out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.owed_beats.size() != 0);
        // a dropped line owes nothing and does not keep the block busy
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cap(logic [6:0] v);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.max_len = v;
    endtask

    // well-formed line with random content, now and then a stray LF, CR or no end
    task automatic send_random_line(int unsigned longest);
        int unsigned n;
        int unsigned pick;
        logic [7:0]  d;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, LINE_MAX + 2)
                                        : $urandom_range(0, longest);
        for (int unsigned i = 0; i < n; i++) begin
            d = 8'($urandom_range(0, 255));
            if (d == ldfr_pkg::CHAR_LF && $urandom_range(0, 9) != 0) begin
                d = 8'h41;
            end
            if ($urandom_range(0, 7) == 0) begin
                d = ldfr_pkg::CHAR_CR;
            end
            send_data(d);
        end
        pick = $urandom_range(0, 19);
        if (pick < 13) begin
            send_data(ldfr_pkg::CHAR_LF);
        end else if (pick < 16) begin
            send_data(ldfr_pkg::CHAR_CR);
            send_data(ldfr_pkg::CHAR_LF);
        end else if (pick < 19) begin
            send_flush();
        end
    endtask

    task automatic random_phase(int target, int unsigned longest);
        while (requests_sent < target) begin
            send_random_line(longest);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ldfr_pkg::FUNC_DATA;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset cap of 64: plain line, blank lines, byte extremes, CR handling
        send_data(8'h41); send_data(8'h42); send_data(ldfr_pkg::CHAR_LF);
        send_data(ldfr_pkg::CHAR_CR); send_data(ldfr_pkg::CHAR_LF);
        send_data(ldfr_pkg::CHAR_LF);
        send_data(8'h00); send_data(8'hFF); send_data(ldfr_pkg::CHAR_CR);
        send_data(ldfr_pkg::CHAR_LF);
        // CR CR x: first CR lands in the line, the second one is held, then placed
        send_data(ldfr_pkg::CHAR_CR); send_data(ldfr_pkg::CHAR_CR); send_data(8'h78);
        send_data(ldfr_pkg::CHAR_LF);
        // held CR at end of stream is stripped, then an empty flush
        send_data(8'h71); send_data(ldfr_pkg::CHAR_CR); send_flush();
        send_flush();

        // cap of one: overlong line, flush while discarding, held CR placed at cap
        write_cap(7'd1);
        send_data(8'h61); send_data(8'h62); send_data(ldfr_pkg::CHAR_LF);
        send_data(8'h61); send_data(8'h62); send_flush();
        send_data(ldfr_pkg::CHAR_CR); send_data(ldfr_pkg::CHAR_CR);
        send_data(ldfr_pkg::CHAR_LF);

        // cap of zero: any nonblank line is overlong
        write_cap(7'd0);
        send_data(8'h61); send_data(ldfr_pkg::CHAR_LF);

        // register above LINE_MAX, then lowered under a buffered line
        write_cap(7'd127);
        send_data(8'h61); send_data(8'h62); send_data(8'h63);
        write_cap(7'd2);
        send_data(ldfr_pkg::CHAR_LF);

        // saturated cap with a long receiver hold-off so the block backs up
        write_cap(7'd127);
        hold_request = 1;
        random_phase(130, 40);

        write_cap(7'd8);
        random_phase(190, 10);

        write_cap(7'd1);
        random_phase(220, 3);

        write_cap(7'd0);
        random_phase(235, 3);

        write_cap(7'($urandom_range(1, 127)));
        random_phase(275, 66);

        // closing stretch at the reset cap without any idling
        write_cap(7'd64);
        idle_on = 0;
        random_phase(330, 66);

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.owed_beats.size() != 0);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed_beats.size() == 0) begin
            $display("line_deframer_with_length_cap_core test passed");
        end else begin
            $display("line_deframer_with_length_cap_core test failed");
        end
        $finish;
    end

endmodule
